// ===== sv/rd_pkg.sv =====
// Shared types and constants for the reversible deque.
// Command and response transaction structs, op and error codes.
// No dependencies.
package rd_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int COUNT_OUT_W   = 5;

    localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

    typedef enum logic [2:0] {
        OP_NOP        = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_REVERSE    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [COUNT_OUT_W-1:0]   count;
        logic                     is_empty;
        logic                     is_full;
        logic                     is_reversed;
        logic [1:0]               error;
    } t_rsp;

endpackage

// ===== sv/reversible_deque.sv =====
// Top level of the reversible deque: ring buffer in one RAM, index/count
// registers, op decode and a three-state sequencer. Depends on rd_pkg, rd_ram.
//
//  channel   | handshake            | payload | direction
//  ----------+----------------------+---------+----------
//  command   | start / busy         | i_cmd   | in
//  response  | o_done (one cycle)   | o_rsp   | out
//
// A transaction runs through three states: the accept cycle (S_IDLE)
// updates the indices and writes a pushed word, S_READ reads the head and
// tail entries, S_RESP presents the result with o_done. The registered RAM
// read sets this. busy is high in S_READ and S_RESP; start is ignored then.
// Synchronous active-low reset empties the deque and clears the reverse flag;
// store contents stay undefined. The receiver cannot stall the response.
module reversible_deque
    import rd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state, n_state;

    // physical ring pointers, count and the reverse flag
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_rev, n_rev;
    logic [1:0]    r_err, n_err;

    logic              accept;
    logic              we;
    logic [IW-1:0]     waddr;
    logic [DATA_W-1:0] rd_head, rd_tail;
    logic              put_head, put_tail, take_head, take_tail;
    logic              cur_empty, cur_full;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
        return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
        return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
    endfunction

    assign accept    = start && !busy;
    assign cur_empty = (r_count == '0);
    assign cur_full  = (r_count == CW'(DEPTH));

    // map logical ends onto physical ends through the reverse flag
    always_comb begin
        put_head  = 1'b0;
        put_tail  = 1'b0;
        take_head = 1'b0;
        take_tail = 1'b0;
        case (i_cmd.op)
            OP_PUSH_BACK:  begin
                put_head = r_rev;
                put_tail = !r_rev;
            end
            OP_PUSH_FRONT: begin
                put_head = !r_rev;
                put_tail = r_rev;
            end
            OP_POP_BACK:   begin
                take_head = r_rev;
                take_tail = !r_rev;
            end
            OP_POP_FRONT:  begin
                take_head = !r_rev;
                take_tail = r_rev;
            end
            default:       ;
        endcase
    end

    // state update in the accept cycle
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_rev   = r_rev;
        n_err   = r_err;
        we      = 1'b0;
        waddr   = r_head;
        if (accept) begin
            n_err = ERR_OK;
            if (i_cmd.op == OP_REVERSE) begin
                n_rev = !r_rev;
            end
            if (put_head || put_tail) begin
                if (cur_full) begin
                    n_err = ERR_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                    if (cur_empty) begin
                        // first entry sits at head, tail is set to the same index
                        n_tail = r_head;
                        waddr  = r_head;
                    end else if (put_tail) begin
                        n_tail = idx_inc(r_tail);
                        waddr  = n_tail;
                    end else begin
                        n_head = idx_dec(r_head);
                        waddr  = n_head;
                    end
                end
            end
            if (take_head || take_tail) begin
                if (cur_empty) begin
                    n_err = ERR_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    if (r_count == CW'(1)) begin
                        n_tail = r_head;
                    end else if (take_tail) begin
                        n_tail = idx_dec(r_tail);
                    end else begin
                        n_head = idx_inc(r_head);
                    end
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_READ;
            S_READ:  n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err <= n_err;
    end

    // reads run in the cycle after the write, so no same-entry overlap
    rd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (i_cmd.value),
        .i_raddr_a (r_head),
        .i_raddr_b (r_tail),
        .o_rdata_a (rd_head),
        .o_rdata_b (rd_tail)
    );

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);

    always_comb begin
        o_rsp.count       = COUNT_OUT_W'(r_count);
        o_rsp.is_empty    = cur_empty;
        o_rsp.is_full     = cur_full;
        o_rsp.is_reversed = r_rev;
        o_rsp.error       = r_err;
        if (cur_empty) begin
            o_rsp.front_value = EMPTY_WORD;
            o_rsp.back_value  = EMPTY_WORD;
        end else begin
            o_rsp.front_value = r_rev ? rd_tail : rd_head;
            o_rsp.back_value  = r_rev ? rd_head : rd_tail;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_resp_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_done)
        else $error("response not two cycles after accept");

    a_full_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.error == ERR_FULL) |-> o_rsp.is_full)
        else $error("full error without full deque");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty deque with split pointers");
`endif

endmodule

// ===== sv/rd_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// Parameterized by word width and depth. No dependencies.
module rd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
